// ===== hw/rtl/rau_pkg.sv =====
// shared types and codes for the rational arithmetic unit
package rau_pkg;
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_EQ   = 3'd4;
    localparam logic [2:0] OP_NE   = 3'd5;
    localparam logic [2:0] OP_NEG  = 3'd6;
    localparam logic [2:0] OP_NORM = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIVZ  = 2'd1;
    localparam logic [1:0] ST_ZDEN  = 2'd2;
    localparam logic [1:0] ST_OVFL  = 2'd3;

    typedef logic [63:0] mag_t;
endpackage

// ===== hw/rtl/rational_arithmetic_unit_top.sv =====
// rational arithmetic unit: cross products, gcd reduction and range check
// One beat is taken at a time; s_tready is low from acceptance until the result beat
// leaves. Every operation runs through 64-bit add, subtract and shift steps: four
// products of 32 shift-add steps each, then a binary gcd, then two restoring divisions
// by the gcd of 64 steps each. The gcd sets most of the time of an arithmetic opcode;
// a comparison, a zero numerator, a zero denominator or a division by zero cuts the gcd
// and the divisions short, though the products are always formed.
module rational_arithmetic_unit_top #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[129:99], zero fill
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_num[31:0], res_den[62:32], compare_true[63], status[65:64], zero fill
    output logic [71:0]  m_tdata
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;
    localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_PREP = 3'd2, S_GCD = 3'd3,
                           S_DIV = 3'd4, S_FIN = 3'd5, S_OUT = 3'd6;
    localparam mag_t LIM = mag_t'(1) << (W - 1);

    logic [2:0]  state_reg, state_next;
    logic [2:0]  op_reg;
    logic [1:0]  pidx_reg;   // which product is being formed
    logic [6:0]  cnt_reg;
    logic [31:0] mx_reg [4];  // multiplicand magnitudes
    logic [31:0] my_reg [4];
    logic        sg_reg [4];
    mag_t        pr_reg [4];  // product magnitudes
    mag_t        acc_reg, mcand_reg;
    logic [31:0] mplier_reg;
    mag_t        nm_reg, dm_reg;
    logic        nneg_reg, dneg_reg;
    mag_t        gu_reg, gv_reg;
    logic [6:0]  gk_reg;
    mag_t        g_reg;
    logic        dsel_reg;   // 0 dividing numerator, 1 denominator
    mag_t        q_reg, r_reg, dd_reg;
    mag_t        qn_reg;
    logic [31:0] rn_reg;
    logic [30:0] rd_reg;
    logic        cmp_reg;
    logic [1:0]  st_reg;

    // operand extraction
    function automatic logic [32:0] sxt(input logic [31:0] v);
        logic [31:0] m;
        m = 32'(signed'(v[W-1:0]));
        return {m[31], m};
    endfunction
    logic [32:0] an, ad, bn;
    logic [31:0] bd;
    assign an = sxt(s_tdata[34:3]);
    assign ad = sxt(s_tdata[66:35]);
    assign bn = sxt(s_tdata[98:67]);
    assign bd = 32'(s_tdata[99 +: W-1]);

    function automatic logic [31:0] absv(input logic [32:0] v);
        return v[32] ? 32'(-v) : v[31:0];
    endfunction

    // signed sum of the two numerator products
    logic  t_neg, u_neg;
    mag_t  sum_mag;
    logic  sum_neg;
    always_comb begin
        u_neg = sg_reg[0] && pr_reg[0] != '0;
        t_neg = (sg_reg[1] ^ (op_reg == OP_SUB)) && pr_reg[1] != '0;
        if (u_neg == t_neg) begin
            sum_mag = pr_reg[0] + pr_reg[1];
            sum_neg = u_neg;
        end else if (pr_reg[0] >= pr_reg[1]) begin
            sum_mag = pr_reg[0] - pr_reg[1];
            sum_neg = u_neg;
        end else begin
            sum_mag = pr_reg[1] - pr_reg[0];
            sum_neg = t_neg;
        end
    end

    mag_t rsh, gdiff;
    assign rsh = {r_reg[62:0], dd_reg[63]};
    assign gdiff = (gu_reg > gv_reg) ? gu_reg - gv_reg : gv_reg - gu_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_MUL;
            S_MUL:   if (cnt_reg == 7'd31 && pidx_reg == 2'd3) state_next = S_PREP;
            S_PREP:  state_next = S_GCD;
            S_GCD:   if (cnt_reg != 7'd0 && (gu_reg == '0 || gv_reg == '0))
                         state_next = S_DIV;
            S_DIV:   if (st_reg != ST_OK || (cnt_reg == 7'd63 && dsel_reg))
                         state_next = S_FIN;
            S_FIN:   state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        case (state_reg)
            S_IDLE: begin
                op_reg <= s_tdata[2:0];
                st_reg <= ST_OK;
                cmp_reg <= 1'b0;
                cnt_reg <= '0;
                pidx_reg <= '0;
                // products: 0 an*bd, 1 ad*bn, 2 den, 3 an*bn
                mx_reg[0] <= absv(an); my_reg[0] <= bd; sg_reg[0] <= an[32];
                mx_reg[1] <= absv(ad); my_reg[1] <= absv(bn); sg_reg[1] <= ad[32] ^ bn[32];
                mx_reg[2] <= absv(ad); my_reg[2] <= bd; sg_reg[2] <= ad[32];
                mx_reg[3] <= absv(an); my_reg[3] <= absv(bn); sg_reg[3] <= an[32] ^ bn[32];
                acc_reg <= '0;
                mcand_reg <= mag_t'(absv(an));
                mplier_reg <= bd;
                if (s_tdata[2:0] == OP_DIV && bn[31:0] == '0) st_reg <= ST_DIVZ;
            end
            S_MUL: begin
                // shift-add step on the accumulator
                if (cnt_reg == 7'd31) begin
                    pr_reg[pidx_reg] <= acc_reg + (mplier_reg[0] ? mcand_reg : '0);
                    acc_reg <= '0;
                    mcand_reg <= mag_t'(mx_reg[pidx_reg + 2'd1]);
                    mplier_reg <= my_reg[pidx_reg + 2'd1];
                    pidx_reg <= pidx_reg + 2'd1;
                    cnt_reg <= '0;
                end else begin
                    acc_reg <= acc_reg + (mplier_reg[0] ? mcand_reg : '0);
                    mcand_reg <= {mcand_reg[62:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[31:1]};
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
            S_PREP: begin
                nneg_reg <= 1'b0; dneg_reg <= 1'b0;
                case (op_reg)
                    OP_ADD, OP_SUB: begin
                        nm_reg <= sum_mag; nneg_reg <= sum_neg;
                        dm_reg <= pr_reg[2]; dneg_reg <= sg_reg[2];
                    end
                    OP_MUL: begin
                        nm_reg <= pr_reg[3]; nneg_reg <= sg_reg[3];
                        dm_reg <= pr_reg[2]; dneg_reg <= sg_reg[2];
                    end
                    OP_DIV: begin
                        nm_reg <= pr_reg[0]; nneg_reg <= sg_reg[0];
                        dm_reg <= pr_reg[1]; dneg_reg <= sg_reg[1];
                    end
                    OP_EQ, OP_NE: begin
                        nm_reg <= '0; dm_reg <= 64'd1;
                        cmp_reg <= ((u_neg == (sg_reg[1] && pr_reg[1] != '0)) &&
                                    pr_reg[0] == pr_reg[1]) ^ (op_reg == OP_NE);
                    end
                    default: begin
                        // negate or normalise: A alone, magnitudes are in the mul operands
                        nm_reg <= mag_t'(mx_reg[3]);
                        nneg_reg <= sg_reg[0] ^ (op_reg == OP_NEG);
                        dm_reg <= mag_t'(mx_reg[2]); dneg_reg <= sg_reg[2];
                    end
                endcase
                gk_reg <= '0;
                cnt_reg <= '0;
            end
            S_GCD: begin
                if (cnt_reg == 7'd0) begin
                    // first cycle: load operands and screen the trivial cases
                    if (dm_reg == '0) begin
                        if (st_reg == ST_OK) st_reg <= ST_ZDEN;
                    end
                    gu_reg <= nm_reg; gv_reg <= dm_reg;
                    if (nm_reg == '0 || dm_reg == '0) begin
                        gu_reg <= '0; gv_reg <= '0;
                    end
                    cnt_reg <= 7'd1;
                end else if (!gu_reg[0] && !gv_reg[0]) begin
                    gu_reg <= gu_reg >> 1; gv_reg <= gv_reg >> 1; gk_reg <= gk_reg + 7'd1;
                end else if (!gu_reg[0]) begin
                    gu_reg <= gu_reg >> 1;
                end else if (!gv_reg[0]) begin
                    gv_reg <= gv_reg >> 1;
                end else if (gu_reg > gv_reg) begin
                    gu_reg <= gdiff;
                end else begin
                    gv_reg <= gdiff;
                end
                if (state_next == S_DIV) begin
                    g_reg <= (gu_reg | gv_reg) << gk_reg[5:0];
                    dd_reg <= nm_reg; r_reg <= '0; q_reg <= '0;
                    cnt_reg <= '0; dsel_reg <= 1'b0;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit a step
                if (nm_reg == '0) begin
                    qn_reg <= '0; q_reg <= 64'd1; dsel_reg <= 1'b1; cnt_reg <= 7'd63;
                end else if (rsh >= g_reg) begin
                    r_reg <= rsh - g_reg;
                    q_reg <= {q_reg[62:0], 1'b1};
                end else begin
                    r_reg <= rsh;
                    q_reg <= {q_reg[62:0], 1'b0};
                end
                if (nm_reg != '0) begin
                    dd_reg <= {dd_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63 && !dsel_reg) begin
                        qn_reg <= (rsh >= g_reg) ? {q_reg[62:0], 1'b1} : {q_reg[62:0], 1'b0};
                        dsel_reg <= 1'b1; dd_reg <= dm_reg; r_reg <= '0; cnt_reg <= '0;
                    end
                end
            end
            S_FIN: begin
                rn_reg <= '0; rd_reg <= 31'd1;
                if (st_reg == ST_OK && op_reg != OP_EQ && op_reg != OP_NE && nm_reg != '0) begin
                    if (q_reg > LIM - 64'd1 ||
                        (nneg_reg ^ dneg_reg ? qn_reg > LIM : qn_reg > LIM - 64'd1)) begin
                        st_reg <= ST_OVFL;
                    end else begin
                        rn_reg <= (nneg_reg ^ dneg_reg) ? 32'(-qn_reg) : qn_reg[31:0];
                        rd_reg <= q_reg[30:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = state_reg == S_OUT;
    assign m_tdata = {6'd0, st_reg, cmp_reg, rd_reg, rn_reg};
endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the rational arithmetic unit
module testbench;
    import rau_pkg::*;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        cmp;
        logic [1:0]  st;
    } rat_result_t;

    // sign-magnitude at double width
    typedef struct {
        bit          neg;
        logic [63:0] mag;
    } sm_val_t;

    function automatic sm_val_t to_sm(longint v);
        sm_val_t r;
        r.neg = v < 0;
        r.mag = r.neg ? -v : v;
        return r;
    endfunction

    function automatic sm_val_t sm_product(longint x, longint y);
        sm_val_t a, b, r;
        a = to_sm(x);
        b = to_sm(y);
        r.mag = a.mag * b.mag;
        r.neg = (a.neg != b.neg) && r.mag != 0;
        return r;
    endfunction

    function automatic sm_val_t sm_sum(sm_val_t a, sm_val_t b);
        sm_val_t r;
        if (a.neg == b.neg) begin
            r.neg = a.neg;
            r.mag = a.mag + b.mag;
        end else if (a.mag >= b.mag) begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end else begin
            r.neg = b.neg;
            r.mag = b.mag - a.mag;
        end
        if (r.mag == 0) r.neg = 0;
        return r;
    endfunction

    // lowest terms plus range check; fills num/den/st of the result
    function automatic rat_result_t lowest_terms(sm_val_t n, sm_val_t d);
        rat_result_t r;
        logic [63:0] x, y, t, lim, nm, dm;
        bit neg;
        r = '0;
        r.den = 31'd1;
        lim = 64'd1 << 31;
        if (d.mag == 0) begin
            r.st = ST_ZDEN;
            return r;
        end
        if (n.mag == 0) return r;
        neg = n.neg != d.neg;
        x = n.mag;
        y = d.mag;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        nm = n.mag / x;
        dm = d.mag / x;
        if (dm > lim - 1 || (neg ? nm > lim : nm > lim - 1)) begin
            r.st = ST_OVFL;
            return r;
        end
        r.num = neg ? 32'(-nm) : nm[31:0];
        r.den = dm[30:0];
        return r;
    endfunction

    function automatic rat_result_t rational_op(logic [2:0] op, logic [31:0] an_r,
                                                logic [31:0] ad_r, logic [31:0] bn_r,
                                                logic [30:0] bd_r);
        rat_result_t r;
        longint an, ad, bn, bd;
        sm_val_t t, n;
        an = longint'(signed'(an_r));
        ad = longint'(signed'(ad_r));
        bn = longint'(signed'(bn_r));
        bd = longint'({33'd0, bd_r});
        r = '0;
        r.den = 31'd1;
        case (op)
            OP_ADD, OP_SUB: begin
                t = sm_product(ad, bn);
                if (op == OP_SUB && t.mag != 0) t.neg = !t.neg;
                r = lowest_terms(sm_sum(sm_product(an, bd), t), sm_product(ad, bd));
            end
            OP_MUL: r = lowest_terms(sm_product(an, bn), sm_product(ad, bd));
            OP_DIV: begin
                if (bn == 0) r.st = ST_DIVZ;
                else r = lowest_terms(sm_product(an, bd), sm_product(ad, bn));
            end
            OP_EQ: r.cmp = (an * bd) == (ad * bn);
            OP_NE: r.cmp = (an * bd) != (ad * bn);
            OP_NEG: begin
                n = to_sm(an);
                if (n.mag != 0) n.neg = !n.neg;
                r = lowest_terms(n, to_sm(ad));
            end
            default: r = lowest_terms(to_sm(an), to_sm(ad));
        endcase
        return r;
    endfunction

    class rat_scoreboard;
        rat_result_t pending[$];
        int errors;
        int checked;

        function void note_operands(logic [135:0] d);
            pending.push_back(rational_op(d[2:0], d[34:3], d[66:35], d[98:67], d[129:99]));
        endfunction

        function void check_result(logic [71:0] d);
            rat_result_t got, want;
            got = {d[31:0], d[62:32], d[63], d[65:64]};
            if (pending.size() == 0) begin
                $display("%0t: result with none expected %h", $realtime, d);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.num !== want.num) begin
                $display("%0t: num exp %h got %h", $realtime, want.num, got.num);
                errors++;
            end
            if (got.den !== want.den) begin
                $display("%0t: den exp %h got %h", $realtime, want.den, got.den);
                errors++;
            end
            if (got.cmp !== want.cmp) begin
                $display("%0t: cmp exp %b got %b", $realtime, want.cmp, got.cmp);
                errors++;
            end
            if (got.st !== want.st) begin
                $display("%0t: status exp %0d got %0d", $realtime, want.st, got.st);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [71:0]  m_tdata;

    rat_scoreboard board = new();
    bit long_holdoff = 0;
    int op_count[8];

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    rational_arithmetic_unit_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_operands(s_tdata);
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (long_holdoff) begin
                m_tready <= 0;
                repeat (2000) @(posedge aclk);
                long_holdoff = 0;
            end
            if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: m_tready <= 1;
                1: m_tready <= $urandom_range(0, 3) != 0;
                default: m_tready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    int gap_left = 0;
    int burst_left = 0;

    task automatic send_beat(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [30:0] bd);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 400);
        end
        if (gap_left > 0) s_tvalid <= 0;
        while (gap_left > 0) begin
            @(posedge aclk);
            gap_left--;
        end
        burst_left--;
        s_tvalid <= 1;
        s_tdata <= {6'd0, bd, bn, ad, an, op};
        op_count[op]++;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return -$urandom_range(0, 20);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            3: return $urandom_range(0, 5000) * ($urandom_range(0, 1) ? 1 : -1);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] an, ad, bn;
        logic [30:0] bd;
        logic [2:0] op;
        logic [31:0] k;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes and each special case
        send_beat(OP_ADD, 1, 2, 1, 3);
        send_beat(OP_SUB, 1, 2, 1, 2);
        send_beat(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
        send_beat(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
        send_beat(OP_DIV, 5, 7, 0, 3);
        send_beat(OP_DIV, 32'h8000_0000, 1, -1, 1);
        send_beat(OP_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 31'h7fff_ffff);
        send_beat(OP_ADD, 1, 0, 1, 1);
        send_beat(OP_ADD, 1, 1, 1, 0);
        send_beat(OP_MUL, 0, 5, 7, 0);
        send_beat(OP_EQ, 2, 4, 1, 2);
        send_beat(OP_EQ, 1, 0, 2, 0);
        send_beat(OP_NE, 1, 3, 1, 2);
        send_beat(OP_NE, 0, 0, 0, 0);
        send_beat(OP_NEG, 32'h8000_0000, 1, 0, 1);
        send_beat(OP_NEG, 32'h8000_0000, -1, 0, 1);
        send_beat(OP_NEG, 6, -4, 0, 1);
        send_beat(OP_NORM, 0, -7, 0, 1);
        send_beat(OP_NORM, 32'h8000_0000, 32'h8000_0000, 0, 1);
        send_beat(OP_NORM, 1, 32'h8000_0000, 0, 1);
        send_beat(OP_NORM, 3, 0, 0, 1);
        send_beat(OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
        send_beat(OP_SUB, 32'h8000_0000, 1, 1, 1);

        for (int i = 0; i < 1100; i++) begin
            if (i == 300) begin
                // let the block drain completely
                s_tvalid <= 0;
                @(posedge aclk);
                while (board.pending.size() != 0) @(posedge aclk);
            end
            if (i == 600) long_holdoff = 1;
            op = 3'($urandom_range(0, 7));
            an = rand_word();
            ad = rand_word();
            bn = rand_word();
            bd = $urandom_range(0, 9) == 0 ? 31'd0 : 31'(rand_word());
            // equal-value pairs so EQ comes out true and NE false often
            if ((op == OP_EQ || op == OP_NE) && $urandom_range(0, 1)) begin
                k = $urandom_range(1, 50);
                bn = an * k;
                bd = 31'(ad * k);
            end
            send_beat(op, an, ad, bn, bd);
        end

        s_tvalid <= 0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        $display("ran %0d results over all eight opcodes (add %0d, div %0d, norm %0d)",
                 board.checked, op_count[OP_ADD], op_count[OP_DIV], op_count[OP_NORM]);
        $display("with bursty input, random output stalls, one long hold-off and a drain");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #10000000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
